/* sv/a2hid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package a2hid_pkg;

    localparam int unsigned C_QUEUE_DEPTH = 2;
    localparam logic [7:0]  C_SHIFT_MOD   = 8'h02;
    localparam logic [7:0]  C_NO_MOD      = 8'h00;
    localparam logic [6:0]  C_NO_KEY      = 7'd0;

    typedef enum logic {
        OP_TYPE = 1'b0,
        OP_LED  = 1'b1
    } t_op;

    // One press report waiting for the back end.
    typedef struct packed {
        logic [7:0] modifier;
        logic [6:0] keycode;
    } t_press;

    // Classification of one character before caps lock is applied.
    typedef struct packed {
        logic       letter;
        logic       shift;
        logic [6:0] keycode;
    } t_class;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_class a2hid_classify(input logic [6:0] ch);
        t_class c;
        c.letter  = 1'b0;
        c.shift   = 1'b0;
        c.keycode = C_NO_KEY;
        priority if (ch >= 7'h41 && ch <= 7'h5A) begin
            c.letter  = 1'b1;
            c.shift   = 1'b1;
            c.keycode = 7'd4 + (ch - 7'h41);
        end else if (ch >= 7'h61 && ch <= 7'h7A) begin
            c.letter  = 1'b1;
            c.keycode = 7'd4 + (ch - 7'h61);
        end else if (ch == 7'h30) begin
            c.keycode = 7'd39;
        end else if (ch >= 7'h31 && ch <= 7'h39) begin
            c.keycode = 7'd30 + (ch - 7'h31);
        end else begin
            unique case (ch)
                7'h21: begin c.shift = 1'b1; c.keycode = 7'd30;  end // !
                7'h40: begin c.shift = 1'b1; c.keycode = 7'd31;  end // @
                7'h23: begin c.shift = 1'b1; c.keycode = 7'd32;  end // #
                7'h24: begin c.shift = 1'b1; c.keycode = 7'd33;  end // $
                7'h25: begin c.shift = 1'b1; c.keycode = 7'd34;  end // %
                7'h5E: begin c.shift = 1'b1; c.keycode = 7'd35;  end // ^
                7'h26: begin c.shift = 1'b1; c.keycode = 7'd36;  end // &
                7'h2A: begin c.shift = 1'b1; c.keycode = 7'd37;  end // *
                7'h28: begin c.shift = 1'b1; c.keycode = 7'd38;  end // (
                7'h29: begin c.shift = 1'b1; c.keycode = 7'h27;  end // )
                7'h7E: begin c.shift = 1'b1; c.keycode = 7'h35;  end // ~
                7'h60: begin                 c.keycode = 7'h35;  end // `
                7'h5F: begin c.shift = 1'b1; c.keycode = 7'h2D;  end // _
                7'h2D: begin                 c.keycode = 7'h2D;  end // -
                7'h2B: begin c.shift = 1'b1; c.keycode = 7'h2E;  end // +
                7'h3D: begin                 c.keycode = 7'h2E;  end // =
                7'h7B: begin c.shift = 1'b1; c.keycode = 7'h2F;  end // {
                7'h5B: begin                 c.keycode = 7'h2F;  end // [
                7'h7D: begin c.shift = 1'b1; c.keycode = 7'h30;  end // }
                7'h5D: begin                 c.keycode = 7'h30;  end // ]
                7'h7C: begin c.shift = 1'b1; c.keycode = 7'h31;  end // |
                7'h5C: begin                 c.keycode = 7'h31;  end // backslash
                7'h3A: begin c.shift = 1'b1; c.keycode = 7'h33;  end // :
                7'h3B: begin                 c.keycode = 7'h33;  end // ;
                7'h22: begin c.shift = 1'b1; c.keycode = 7'h34;  end // double quote
                7'h27: begin                 c.keycode = 7'h34;  end // quote
                7'h3C: begin c.shift = 1'b1; c.keycode = 7'h36;  end // <
                7'h2C: begin                 c.keycode = 7'h36;  end // ,
                7'h3E: begin c.shift = 1'b1; c.keycode = 7'h37;  end // >
                7'h2E: begin                 c.keycode = 7'h37;  end // .
                7'h3F: begin c.shift = 1'b1; c.keycode = 7'h38;  end // ?
                7'h2F: begin                 c.keycode = 7'h38;  end // /
                7'h20: begin                 c.keycode = 7'h2C;  end // space
                7'h09: begin                 c.keycode = 7'h2B;  end // tab
                7'h0A: begin                 c.keycode = 7'h28;  end // newline
                default: begin               c.keycode = C_NO_KEY; end
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/a2hid_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2hid_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_operation,
    input  wire logic [6:0]          i_char_code,
    input  wire logic [7:0]          i_led_bits,
    input  wire a2hid_pkg::t_qstat   i_qstat,
    output logic                     o_push,
    output a2hid_pkg::t_press        o_press
);

    logic              r_caps_lock;
    logic              n_caps_lock;
    logic              w_accept;
    a2hid_pkg::t_class w_class;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;
    assign w_class  = a2hid_pkg::a2hid_classify(i_char_code);

    // Letters flip shift while caps lock is on so the host sees the intended case.
    always_comb begin
        o_press.keycode  = w_class.keycode;
        o_press.modifier = (w_class.shift ^ (w_class.letter & r_caps_lock))
                         ? a2hid_pkg::C_SHIFT_MOD : a2hid_pkg::C_NO_MOD;
        o_push = w_accept && (a2hid_pkg::t_op'(i_operation) == a2hid_pkg::OP_TYPE);
    end

    always_comb begin
        n_caps_lock = r_caps_lock;
        if (w_accept && (a2hid_pkg::t_op'(i_operation) == a2hid_pkg::OP_LED)) begin
            n_caps_lock = i_led_bits[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps_lock <= 1'b0;
        end else begin
            r_caps_lock <= n_caps_lock;
        end
    end

endmodule

`default_nettype wire

/* sv/a2hid_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2hid_queue #(
    parameter int unsigned DEPTH = a2hid_pkg::C_QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire a2hid_pkg::t_press   i_data,
    input  wire logic                i_pop,
    output a2hid_pkg::t_press        o_data,
    output a2hid_pkg::t_qstat        o_qstat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    a2hid_pkg::t_press r_mem [DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     n_wptr;
    logic [PW-1:0]     n_rptr;
    logic [CW-1:0]     n_count;
    logic              w_push;
    logic              w_pop;

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_data        = r_mem[r_rptr];

    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* sv/a2hid_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2hid_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire a2hid_pkg::t_qstat   i_qstat,
    input  wire a2hid_pkg::t_press   i_press,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_modifier,
    output logic [6:0]               o_keycode,
    output logic                     o_last
);

    logic       r_valid;
    logic       r_last;
    logic [7:0] r_modifier;
    logic [6:0] r_keycode;
    logic       n_valid;
    logic       n_last;
    logic [7:0] n_modifier;
    logic [6:0] n_keycode;
    logic       w_advance;
    logic       w_release;

    assign w_advance = !r_valid || i_ready;
    // A press just left (or is leaving) the register: the release goes next.
    assign w_release = r_valid && !r_last;
    assign o_pop     = w_advance && !w_release && !i_qstat.empty;

    always_comb begin
        n_valid    = r_valid;
        n_last     = r_last;
        n_modifier = r_modifier;
        n_keycode  = r_keycode;
        if (w_advance) begin
            priority if (w_release) begin
                n_valid    = 1'b1;
                n_last     = 1'b1;
                n_modifier = a2hid_pkg::C_NO_MOD;
                n_keycode  = a2hid_pkg::C_NO_KEY;
            end else if (!i_qstat.empty) begin
                n_valid    = 1'b1;
                n_last     = 1'b0;
                n_modifier = i_press.modifier;
                n_keycode  = i_press.keycode;
            end else begin
                n_valid    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b1;
        end else begin
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_modifier <= n_modifier;
        r_keycode  <= n_keycode;
    end

    assign o_valid    = r_valid;
    assign o_last     = r_last;
    assign o_modifier = r_modifier;
    assign o_keycode  = r_keycode;

endmodule

`default_nettype wire

/* sv/ascii_to_hid_keystroke_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Converts 7-bit ASCII characters into USB HID boot-keyboard reports. A type
// transaction yields a press report (left shift 0x02 when needed, usage code)
// and then an all-zero release report with o_last set; an LED transaction
// stores caps lock from bit 1 of i_led_bits and yields nothing. The input side
// takes one transaction per cycle while the press queue (QUEUE_DEPTH entries)
// has room; the output register sends each character as a press and then a
// release, and holds a report while i_ready is low. A character's press
// passes through the press queue and then the output register on its way to
// the output. Caps lock changes apply to characters accepted after the LED
// transaction.
module ascii_to_hid_keystroke_core #(
    parameter int unsigned QUEUE_DEPTH = a2hid_pkg::C_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_operation,
    input  wire logic [6:0] i_char_code,
    input  wire logic [7:0] i_led_bits,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_modifier,
    output logic [6:0]      o_keycode,
    output logic            o_last
);

    a2hid_pkg::t_qstat w_qstat;
    a2hid_pkg::t_press w_push_data;
    a2hid_pkg::t_press w_pop_data;
    logic              w_push;
    logic              w_pop;

    a2hid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_led_bits  (i_led_bits),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_press     (w_push_data)
    );

    a2hid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_qstat (w_qstat)
    );

    a2hid_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (w_qstat),
        .i_press    (w_pop_data),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_modifier (o_modifier),
        .o_keycode  (o_keycode),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

/* sv/a2hid_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2hid_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_modifier,
    input wire logic [6:0] o_keycode,
    input wire logic       o_last
);

    // Hold a stalled report steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_modifier) && $stable(o_keycode)
            && $stable(o_last))
        else $error("output transaction changed while stalled");

    // A press is always followed at once by its release.
    a_release_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_last)
        else $error("press not followed by release");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_modifier == a2hid_pkg::C_NO_MOD
            && o_keycode == a2hid_pkg::C_NO_KEY)
        else $error("release report not all zero");

    a_press_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> (o_modifier == a2hid_pkg::C_NO_MOD
            || o_modifier == a2hid_pkg::C_SHIFT_MOD) && o_keycode <= 7'd101)
        else $error("press report out of range");

endmodule

bind ascii_to_hid_keystroke_core a2hid_checker u_a2hid_checker (.*);

`default_nettype wire

/* bench/ascii_to_hid_keystroke_core_test.sv */
`timescale 1ns / 1ps

module ascii_to_hid_keystroke_core_test;

    typedef struct packed {
        logic [7:0] modifier;
        logic [6:0] keycode;
        logic       last;
    } t_report;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic       i_operation = 1'b0;
    logic [6:0] i_char_code = 7'd0;
    logic [7:0] i_led_bits  = 8'd0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [7:0] o_modifier;
    logic [6:0] o_keycode;
    logic       o_last;

    // Reports still owed by the block, oldest first.
    t_report    pending_reports[$];
    logic       caps_lock_seen = 1'b0;
    // Bit 7: shift needed, bits 6..0: usage code, for non-alphanumeric characters.
    logic [7:0] symbol_usage [0:127];

    int         n_errors     = 0;
    bit         tx_steady    = 1'b0;
    bit         rx_steady    = 1'b0;
    int         rx_hold_req  = 0;
    int         rx_idle_left = 0;

    ascii_to_hid_keystroke_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_led_bits  (i_led_bits),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_modifier  (o_modifier),
        .o_keycode   (o_keycode),
        .o_last      (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int c = 0; c < 128; c++) symbol_usage[c] = 8'h00;
        symbol_usage[7'h21] = {1'b1, 7'd30};
        symbol_usage[7'h40] = {1'b1, 7'd31};
        symbol_usage[7'h23] = {1'b1, 7'd32};
        symbol_usage[7'h24] = {1'b1, 7'd33};
        symbol_usage[7'h25] = {1'b1, 7'd34};
        symbol_usage[7'h5E] = {1'b1, 7'd35};
        symbol_usage[7'h26] = {1'b1, 7'd36};
        symbol_usage[7'h2A] = {1'b1, 7'd37};
        symbol_usage[7'h28] = {1'b1, 7'd38};
        symbol_usage[7'h29] = {1'b1, 7'h27};
        symbol_usage[7'h7E] = {1'b1, 7'h35};
        symbol_usage[7'h60] = {1'b0, 7'h35};
        symbol_usage[7'h5F] = {1'b1, 7'h2D};
        symbol_usage[7'h2D] = {1'b0, 7'h2D};
        symbol_usage[7'h2B] = {1'b1, 7'h2E};
        symbol_usage[7'h3D] = {1'b0, 7'h2E};
        symbol_usage[7'h7B] = {1'b1, 7'h2F};
        symbol_usage[7'h5B] = {1'b0, 7'h2F};
        symbol_usage[7'h7D] = {1'b1, 7'h30};
        symbol_usage[7'h5D] = {1'b0, 7'h30};
        symbol_usage[7'h7C] = {1'b1, 7'h31};
        symbol_usage[7'h5C] = {1'b0, 7'h31};
        symbol_usage[7'h3A] = {1'b1, 7'h33};
        symbol_usage[7'h3B] = {1'b0, 7'h33};
        symbol_usage[7'h22] = {1'b1, 7'h34};
        symbol_usage[7'h27] = {1'b0, 7'h34};
        symbol_usage[7'h3C] = {1'b1, 7'h36};
        symbol_usage[7'h2C] = {1'b0, 7'h36};
        symbol_usage[7'h3E] = {1'b1, 7'h37};
        symbol_usage[7'h2E] = {1'b0, 7'h37};
        symbol_usage[7'h3F] = {1'b1, 7'h38};
        symbol_usage[7'h2F] = {1'b0, 7'h38};
        symbol_usage[7'h20] = {1'b0, 7'h2C};
        symbol_usage[7'h09] = {1'b0, 7'h2B};
        symbol_usage[7'h0A] = {1'b0, 7'h28};
    end

    function automatic t_report press_report(input logic [6:0] ch, input logic caps);
        t_report r;
        logic    shift;
        r.last = 1'b0;
        if (ch >= 7'h41 && ch <= 7'h5A) begin
            r.keycode = 7'd4 + (ch - 7'h41);
            shift     = ~caps;
        end else if (ch >= 7'h61 && ch <= 7'h7A) begin
            r.keycode = 7'd4 + (ch - 7'h61);
            shift     = caps;
        end else if (ch == 7'h30) begin
            r.keycode = 7'd39;
            shift     = 1'b0;
        end else if (ch >= 7'h31 && ch <= 7'h39) begin
            r.keycode = 7'd30 + (ch - 7'h31);
            shift     = 1'b0;
        end else begin
            r.keycode = symbol_usage[ch][6:0];
            shift     = symbol_usage[ch][7];
        end
        r.modifier = shift ? a2hid_pkg::C_SHIFT_MOD : a2hid_pkg::C_NO_MOD;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [6:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 7'h41 + 7'($urandom_range(0, 25));
        if (r < 4) return 7'h61 + 7'($urandom_range(0, 25));
        if (r < 6) return 7'($urandom_range(7'h20, 7'h40));
        if (r < 7) return ($urandom_range(0, 3) == 0) ? 7'h7F : 7'($urandom_range(0, 7'h1F));
        return 7'($urandom_range(0, 127));
    endfunction

    // Offer one transaction; return once it is accepted and any gap after it has passed,
    // with valid left high only if the next transaction follows without a gap.
    task automatic send_item(input a2hid_pkg::t_op op, input logic [6:0] ch,
                             input logic [7:0] leds);
        int      gap;
        t_report release_r;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_char_code <= ch;
        i_led_bits  <= leds;
        do @(posedge i_clk); while (!o_ready);
        if (op == a2hid_pkg::OP_LED) begin
            caps_lock_seen = leds[1];
        end else begin
            release_r.modifier = a2hid_pkg::C_NO_MOD;
            release_r.keycode  = a2hid_pkg::C_NO_KEY;
            release_r.last     = 1'b1;
            pending_reports.push_back(press_report(ch, caps_lock_seen));
            pending_reports.push_back(release_r);
        end
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 15) begin
            send_item(a2hid_pkg::OP_LED, 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)));
        end else begin
            send_item(a2hid_pkg::OP_TYPE, pick_char(), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [6:0] chars [0:14];
        chars = '{7'h00, 7'h7F, 7'h41, 7'h5A, 7'h61, 7'h7A, 7'h30, 7'h31,
                  7'h39, 7'h21, 7'h7E, 7'h20, 7'h09, 7'h0A, 7'h1B};
        foreach (chars[k]) send_item(a2hid_pkg::OP_TYPE, chars[k], k[0] ? 8'hFF : 8'h00);
        send_item(a2hid_pkg::OP_LED, 7'h7F, 8'hFF);
        send_item(a2hid_pkg::OP_TYPE, 7'h41, 8'h00);
        send_item(a2hid_pkg::OP_TYPE, 7'h7A, 8'h00);
        send_item(a2hid_pkg::OP_TYPE, 7'h21, 8'h00);
        // Every bit but caps lock set: caps goes off.
        send_item(a2hid_pkg::OP_LED, 7'h00, 8'hFD);
        send_item(a2hid_pkg::OP_TYPE, 7'h51, 8'hFF);
        send_item(a2hid_pkg::OP_LED, 7'h55, 8'h02);
        send_item(a2hid_pkg::OP_TYPE, 7'h71, 8'h02);
        send_item(a2hid_pkg::OP_LED, 7'h2A, 8'h00);
        send_item(a2hid_pkg::OP_TYPE, 7'h7F, 8'hFF);
        wait_drained();
    endtask

    task automatic test_code_sweep();
        for (int caps = 0; caps < 2; caps++) begin
            send_item(a2hid_pkg::OP_LED, 7'($urandom_range(0, 127)),
                      (8'($urandom_range(0, 255)) & 8'hFD) | (caps[0] ? 8'h02 : 8'h00));
            for (int c = 0; c < 128; c++) begin
                send_item(a2hid_pkg::OP_TYPE, 7'(c), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_mix(input int n_items);
        repeat (n_items) send_random_item();
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input.
    task automatic test_receiver_stall();
        rx_hold_req = 400;
        tx_steady   = 1'b1;
        repeat (40) send_item(a2hid_pkg::OP_TYPE, pick_char(), 8'($urandom_range(0, 255)));
        tx_steady   = 1'b0;
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_mix(150);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_code_sweep();
        test_random_mix(1000);
        test_receiver_stall();
        test_back_to_back();
        test_random_mix(150);
        wait_drained();
        if (n_errors == 0) begin
            $display("[ascii_to_hid_keystroke_core] OK");
        end else begin
            $display("[ascii_to_hid_keystroke_core] ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[ascii_to_hid_keystroke_core] ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                rx_idle_left = rx_hold_req;
                rx_hold_req  = 0;
            end else if (rx_idle_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
                rx_idle_left = pick_gap();
            end
            if (!i_rst_n || rx_idle_left > 0) begin
                i_ready <= 1'b0;
                if (rx_idle_left > 0) rx_idle_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_report exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with none expected: modifier %0h keycode %0h last %0b",
                       o_modifier, o_keycode, o_last);
                n_errors++;
            end else begin
                exp_r = pending_reports.pop_front();
                if (o_modifier !== exp_r.modifier) begin
                    $error("modifier: expected %0h, actual %0h", exp_r.modifier, o_modifier);
                    n_errors++;
                end
                if (o_keycode !== exp_r.keycode) begin
                    $error("keycode: expected %0h, actual %0h", exp_r.keycode, o_keycode);
                    n_errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0b, actual %0b", exp_r.last, o_last);
                    n_errors++;
                end
            end
        end
    end

endmodule

/* filelist.f */
sv/a2hid_pkg.sv
sv/a2hid_front.sv
sv/a2hid_queue.sv
sv/a2hid_back.sv
sv/ascii_to_hid_keystroke_core.sv
sv/a2hid_checker.sv
bench/ascii_to_hid_keystroke_core_test.sv
